// File: sv/dvrt_pkg.sv
// ---------------------------------------------------------------------------
// dvrt_pkg
// Shared field widths, operation and status codes for the route table.
// ---------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 5;
  localparam int HOP_W     = 5;
  localparam int COST_IN_W = 8;
  localparam int STATUS_W  = 2;

  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [HOP_W-1:0]     hop_t;
  typedef logic [COST_IN_W-1:0] cost_in_t;
  typedef logic [STATUS_W-1:0]  status_t;

  // operation codes
  localparam func_t FUNC_ADVERT = 2'd0;
  localparam func_t FUNC_LOOKUP = 2'd1;
  localparam func_t FUNC_SET    = 2'd2;
  localparam func_t FUNC_DOWN   = 2'd3;

  // result status codes
  localparam status_t STAT_DIRECT  = 2'd0;
  localparam status_t STAT_DEFAULT = 2'd1;
  localparam status_t STAT_NONE    = 2'd2;
  localparam status_t STAT_UPDATED = 2'd3;

endpackage

`default_nettype wire

// File: sv/dvrt_in_if.sv
// ---------------------------------------------------------------------------
// dvrt_in_if
// Request channel: one operation on the route table per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface dvrt_in_if;
  import dvrt_pkg::*;

  logic     valid;
  logic     ready;
  func_t    func;
  index_t   table_index;
  hop_t     src_node;
  hop_t     hop_in;
  cost_in_t cost_in;

  modport source (output valid, func, table_index, src_node, hop_in, cost_in,
                  input ready);
  modport sink   (input valid, func, table_index, src_node, hop_in, cost_in,
                  output ready);
endinterface

`default_nettype wire

// File: sv/dvrt_out_if.sv
// ---------------------------------------------------------------------------
// dvrt_out_if
// Result channel: one route or update report per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface dvrt_out_if;
  import dvrt_pkg::*;

  logic     valid;
  logic     ready;
  hop_t     route_hop;
  cost_in_t route_cost;
  status_t  status;

  modport source (output valid, route_hop, route_cost, status, input ready);
  modport sink   (input valid, route_hop, route_cost, status, output ready);
endinterface

`default_nettype wire

// File: sv/dvrt_store.sv
// ---------------------------------------------------------------------------
// dvrt_store
// Entry store: next hop and cost per destination, one registered read port
// and one write port. Entries never written read as unreachable, hop zero.
// ---------------------------------------------------------------------------
`default_nettype none

module dvrt_store #(
  parameter int NUM_NODES = 32,
  parameter int INF_COST  = 255,
  localparam int IDX_W    = $clog2(NUM_NODES),
  localparam int COST_W   = $clog2(INF_COST)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output dvrt_pkg::hop_t    rd_hop,
  output logic [COST_W-1:0] rd_cost,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  dvrt_pkg::hop_t    wr_hop,
  input  logic [COST_W-1:0] wr_cost
);
  import dvrt_pkg::*;

  localparam logic [COST_W-1:0] UNREACH = COST_W'(INF_COST - 1);

  hop_t              hop_mem  [NUM_NODES];
  logic [COST_W-1:0] cost_mem [NUM_NODES];
  logic [NUM_NODES-1:0] vld;

  hop_t              hop_q;
  logic [COST_W-1:0] cost_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hop_mem[wr_addr]  <= wr_hop;
      cost_mem[wr_addr] <= wr_cost;
    end
    if (rd_en) begin
      hop_q  <= hop_mem[rd_addr];
      cost_q <= cost_mem[rd_addr];
    end
  end

  // unwritten entries read as hop zero and unreachable cost
  assign rd_hop  = vld_q ? hop_q  : '0;
  assign rd_cost = vld_q ? cost_q : UNREACH;

endmodule

`default_nettype wire

// File: sv/distance_vector_route_table.sv
// ---------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector route table with advertise, lookup, set and link-down.
// ---------------------------------------------------------------------------
// One request is taken at a time. Advertise, set entry, link down and a
// lookup whose direct entry is reachable pass from one accepted beat to the
// next through the read, evaluate, result and idle states; a lookup that
// falls back to a default route scans the entry store one entry per cycle
// through its single read port. The result sits in an output register, so
// a new request is taken while it waits.
// Unwritten entries are tracked by valid bits; no clearing pass after reset.
`default_nettype none

module distance_vector_route_table #(
  parameter int NUM_NODES = 32,
  parameter int INF_COST  = 255
) (
  input  logic       clk,
  input  logic       rst,
  dvrt_in_if.sink    in_ch,
  dvrt_out_if.source out_ch
);
  import dvrt_pkg::*;

  localparam int IDX_W  = $clog2(NUM_NODES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int COST_W = $clog2(INF_COST);
  localparam int CMP_W  = ((COST_W > COST_IN_W) ? COST_W : COST_IN_W) + 1;
  localparam logic [COST_W-1:0] UNREACH = COST_W'(INF_COST - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;

  // latched request
  func_t    op_func;
  index_t   op_index;
  hop_t     op_src;
  hop_t     op_hop;
  cost_in_t op_cost;

  logic [CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic             scan_pend, scan_pend_next;

  hop_t              res_hop, res_hop_next;
  logic [COST_W-1:0] res_cost, res_cost_next;
  status_t           res_status, res_status_next;
  logic              res_load;

  logic              out_valid;
  logic              out_free;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  hop_t              rd_hop;
  logic [COST_W-1:0] rd_cost;
  logic              wr_en;
  hop_t              wr_hop;
  logic [COST_W-1:0] wr_cost;

  logic              in_range;
  logic [IDX_W-1:0]  op_addr;

  // shared compare unit
  logic [CMP_W-1:0]  cmp_a, cmp_b;
  logic              cmp_lt;

  assign in_range = 32'(op_index) < NUM_NODES;
  assign op_addr  = IDX_W'(op_index);
  assign cmp_lt   = cmp_a < cmp_b;
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;

  dvrt_store #(
    .NUM_NODES (NUM_NODES),
    .INF_COST  (INF_COST)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_hop  (rd_hop),
    .rd_cost (rd_cost),
    .wr_en   (wr_en),
    .wr_addr (op_addr),
    .wr_hop  (wr_hop),
    .wr_cost (wr_cost)
  );

  always_comb begin
    state_next      = state;
    scan_cnt_next   = scan_cnt;
    scan_pend_next  = scan_pend;
    res_hop_next    = res_hop;
    res_cost_next   = res_cost;
    res_status_next = res_status;
    res_load        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = op_addr;
    wr_en           = 1'b0;
    wr_hop          = rd_hop;
    wr_cost         = rd_cost;
    cmp_a           = CMP_W'(rd_cost);
    cmp_b           = CMP_W'(UNREACH);

    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (op_func == FUNC_LOOKUP) begin
          if (in_range && cmp_lt) begin
            res_hop_next    = rd_hop;
            res_cost_next   = rd_cost;
            res_status_next = STAT_DIRECT;
            state_next      = S_DONE;
          end else begin
            scan_cnt_next  = '0;
            scan_pend_next = 1'b0;
            state_next     = S_SCAN;
          end
        end else begin
          unique case (op_func)
            FUNC_ADVERT: begin
              cmp_a = CMP_W'(op_cost);
              cmp_b = CMP_W'(rd_cost);
              if (cmp_lt) begin
                // strictly cheaper, so cost plus one stays at or below unreachable
                wr_cost = COST_W'(CMP_W'(op_cost) + CMP_W'(1));
                wr_hop  = op_src;
              end else if (op_hop == op_src) begin
                // neighbour routes through us: poison
                wr_cost = UNREACH;
                wr_hop  = op_src;
              end
            end
            FUNC_SET: begin
              cmp_a   = CMP_W'(UNREACH);
              cmp_b   = CMP_W'(op_cost);
              wr_cost = cmp_lt ? UNREACH : COST_W'(op_cost);
              wr_hop  = op_hop;
            end
            default: begin
              wr_cost = UNREACH;
              wr_hop  = '0;
            end
          endcase
          if (in_range) begin
            wr_en         = 1'b1;
            res_hop_next  = wr_hop;
            res_cost_next = wr_cost;
          end else begin
            res_hop_next  = '0;
            res_cost_next = UNREACH;
          end
          res_status_next = STAT_UPDATED;
          state_next      = S_DONE;
        end
      end
      S_SCAN: begin
        // read data belongs to entry scan_cnt - 1
        rd_addr = scan_cnt[IDX_W-1:0];
        if (scan_pend && cmp_lt) begin
          res_hop_next    = rd_hop;
          res_cost_next   = rd_cost;
          res_status_next = STAT_DEFAULT;
          state_next      = S_DONE;
        end else if (!scan_pend && (32'(scan_cnt) == NUM_NODES)) begin
          res_hop_next    = '0;
          res_cost_next   = UNREACH;
          res_status_next = STAT_NONE;
          state_next      = S_DONE;
        end else begin
          rd_en          = (32'(scan_cnt) < NUM_NODES);
          scan_pend_next = rd_en;
          scan_cnt_next  = rd_en ? scan_cnt + CNT_W'(1) : scan_cnt;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      scan_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      scan_pend <= scan_pend_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_func  <= in_ch.func;
      op_index <= in_ch.table_index;
      op_src   <= in_ch.src_node;
      op_hop   <= in_ch.hop_in;
      op_cost  <= in_ch.cost_in;
    end
    res_hop    <= res_hop_next;
    res_cost   <= res_cost_next;
    res_status <= res_status_next;
    if (res_load) begin
      out_ch.route_hop  <= res_hop;
      out_ch.route_cost <= COST_IN_W'(res_cost);
      out_ch.status     <= res_status;
    end
  end

  // a new result only ever comes out of the result stage
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (state == S_DONE))
    else $error("result loaded outside result stage");

  // every accepted beat is followed by a store read of its entry
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == S_READ))
    else $error("accepted beat not followed by entry read");

  // the store is never written for a destination beyond the table
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (in_range && state == S_EVAL && op_func != FUNC_LOOKUP))
    else $error("store write for lookup or out-of-range entry");

  // the scan never runs past the last entry
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (32'(scan_cnt) <= NUM_NODES))
    else $error("default route scan past end of table");

endmodule

`default_nettype wire

// File: test/tb_distance_vector_route_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_distance_vector_route_table
// Self-checking bench for the distance-vector route table. A scoreboard keeps
// its own copy of the next-hop and cost stores, predicts the report for every
// accepted request and compares each result beat in order. A short directed
// sequence hits the empty table, poisoning, cost saturation and the default
// route, then random requests run in phases with bursty input and a stalling
// result side.
// ---------------------------------------------------------------------------

module tb_distance_vector_route_table;
  import dvrt_pkg::*;

  localparam int NUM_NODES  = 32;
  localparam int INF_COST   = 255;
  localparam cost_in_t UNREACH = cost_in_t'(INF_COST - 1);
  localparam int RAND_ITEMS = 800;
  localparam int PHASES     = 4;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    func_t    func;
    index_t   idx;
    hop_t     src;
    hop_t     hop;
    cost_in_t cost;
  } route_req_t;

  typedef struct packed {
    hop_t     route_hop;
    cost_in_t route_cost;
    status_t  status;
  } route_result_t;

  class route_scoreboard;
    hop_t          hop_tbl[NUM_NODES];
    cost_in_t      cost_tbl[NUM_NODES];
    route_result_t expected_q[$];
    int            errors;
    int            func_seen[4];
    int            status_seen[4];

    function new();
      for (int i = 0; i < NUM_NODES; i++) begin
        hop_tbl[i]  = '0;
        cost_tbl[i] = UNREACH;
      end
      errors = 0;
      for (int i = 0; i < 4; i++) begin
        func_seen[i]   = 0;
        status_seen[i] = 0;
      end
    endfunction

    // update the shadow table and queue the report this request causes
    function void note_request(route_req_t r);
      route_result_t res;
      bit            found;
      int            c;
      int            i;
      func_seen[r.func]++;
      if (r.func == FUNC_LOOKUP) begin
        found = 1'b0;
        if (int'(r.idx) < NUM_NODES && cost_tbl[r.idx] < UNREACH) begin
          res   = '{hop_tbl[r.idx], cost_tbl[r.idx], STAT_DIRECT};
          found = 1'b1;
        end
        // fall back to the first reachable entry
        for (i = 0; i < NUM_NODES; i++) begin
          if (!found && cost_tbl[i] < UNREACH) begin
            res   = '{hop_tbl[i], cost_tbl[i], STAT_DEFAULT};
            found = 1'b1;
          end
        end
        if (!found) res = '{hop_t'(0), UNREACH, STAT_NONE};
      end else if (int'(r.idx) >= NUM_NODES) begin
        res = '{hop_t'(0), UNREACH, STAT_UPDATED};
      end else begin
        case (r.func)
          FUNC_ADVERT: begin
            if (r.cost < cost_tbl[r.idx]) begin
              c = int'(r.cost) + 1;
              if (c > int'(UNREACH)) c = int'(UNREACH);
              cost_tbl[r.idx] = cost_in_t'(c);
              hop_tbl[r.idx]  = r.src;
            end else if (r.hop == r.src) begin
              // poison reverse: neighbour routes back through the sender
              cost_tbl[r.idx] = UNREACH;
              hop_tbl[r.idx]  = r.src;
            end
          end
          FUNC_SET: begin
            hop_tbl[r.idx]  = r.hop;
            cost_tbl[r.idx] = (r.cost > UNREACH) ? UNREACH : r.cost;
          end
          default: begin
            hop_tbl[r.idx]  = '0;
            cost_tbl[r.idx] = UNREACH;
          end
        endcase
        res = '{hop_tbl[r.idx], cost_tbl[r.idx], STAT_UPDATED};
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(route_result_t got);
      route_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing outstanding: hop %0d cost %0d status %0d",
               got.route_hop, got.route_cost, got.status);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      status_seen[got.status]++;
      if (got.route_hop !== exp_res.route_hop) begin
        $error("route_hop: expected %0d, got %0d", exp_res.route_hop, got.route_hop);
        errors++;
      end
      if (got.route_cost !== exp_res.route_cost) begin
        $error("route_cost: expected %0d, got %0d", exp_res.route_cost, got.route_cost);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   burst_left;
  route_scoreboard sb;

  dvrt_in_if  in_ch();
  dvrt_out_if out_ch();

  distance_vector_route_table #(
    .NUM_NODES(NUM_NODES),
    .INF_COST (INF_COST)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  // accepted beats on both channels, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(route_req_t'{in_ch.func, in_ch.table_index, in_ch.src_node,
                                     in_ch.hop_in, in_ch.cost_in});
      if (out_ch.valid && out_ch.ready)
        sb.check_result(route_result_t'{out_ch.route_hop, out_ch.route_cost,
                                        out_ch.status});
    end
  end

  // result side: a random stall mode is held for a random-length run, then picked anew
  initial begin
    int mode;
    int left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 99) < 60);
        2:       out_ch.ready <= (cycle_count % 5 == 0);
        default: out_ch.ready <= ($urandom_range(0, 99) < 15);
      endcase
    end
  end

  function automatic route_req_t mk_req(func_t f, index_t idx, hop_t src, hop_t hop,
                                        cost_in_t cost);
    route_req_t r;
    r = '{f, idx, src, hop, cost};
    return r;
  endfunction

  // phase 0 all four operations mixed, 1 contention on few entries, 2 link-down heavy, 3 set heavy
  function automatic route_req_t make_random_req(int phase);
    route_req_t r;
    int pick;
    int sel;
    int w_adv;
    int w_look;
    int w_set;
    case (phase)
      0:       begin w_adv = 35; w_look = 30; w_set = 20; end
      1:       begin w_adv = 50; w_look = 25; w_set = 15; end
      2:       begin w_adv = 5;  w_look = 40; w_set = 5;  end
      default: begin w_adv = 25; w_look = 30; w_set = 35; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < w_adv)                       r.func = FUNC_ADVERT;
    else if (pick < w_adv + w_look)         r.func = FUNC_LOOKUP;
    else if (pick < w_adv + w_look + w_set) r.func = FUNC_SET;
    else                                    r.func = FUNC_DOWN;
    if (phase == 1 && $urandom_range(0, 99) < 80)
      r.idx = index_t'($urandom_range(0, 3));
    else
      r.idx = index_t'($urandom_range(0, NUM_NODES - 1));
    r.src = hop_t'($urandom_range(0, 31));
    r.hop = ($urandom_range(0, 9) < 4) ? r.src : hop_t'($urandom_range(0, 31));
    sel = $urandom_range(0, 9);
    if (sel < 5)      r.cost = cost_in_t'($urandom_range(0, 20));
    else if (sel < 7) r.cost = cost_in_t'($urandom_range(250, 255));
    else              r.cost = cost_in_t'($urandom_range(0, 255));
    return r;
  endfunction

  // entered and left at a falling edge; bursts of beats with random gaps
  task automatic drive_req(route_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= r.func;
    in_ch.table_index <= r.idx;
    in_ch.src_node    <= r.src;
    in_ch.hop_in      <= r.hop;
    in_ch.cost_in     <= r.cost;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  initial begin
    sb          = new();
    burst_left  = 0;
    rst         = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_ADVERT;
    in_ch.table_index = '0;
    in_ch.src_node    = '0;
    in_ch.hop_in      = '0;
    in_ch.cost_in     = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table, then poisoning and saturation on one entry
    drive_req(mk_req(FUNC_LOOKUP, 0, 0, 0, 0));
    drive_req(mk_req(FUNC_LOOKUP, 31, 31, 31, 255));
    drive_req(mk_req(FUNC_ADVERT, 5, 3, 7, 255));
    drive_req(mk_req(FUNC_ADVERT, 5, 3, 3, 254));
    drive_req(mk_req(FUNC_LOOKUP, 5, 0, 0, 0));
    drive_req(mk_req(FUNC_ADVERT, 5, 31, 0, 253));
    drive_req(mk_req(FUNC_ADVERT, 5, 2, 9, 0));
    drive_req(mk_req(FUNC_LOOKUP, 5, 0, 0, 0));
    drive_req(mk_req(FUNC_LOOKUP, 0, 0, 0, 0));
    // set entry at both cost extremes, default route to the lowest entry
    drive_req(mk_req(FUNC_SET, 31, 0, 31, 255));
    drive_req(mk_req(FUNC_SET, 0, 0, 31, 0));
    drive_req(mk_req(FUNC_LOOKUP, 31, 0, 0, 0));
    drive_req(mk_req(FUNC_SET, 31, 0, 16, 254));
    drive_req(mk_req(FUNC_SET, 31, 0, 1, 253));
    drive_req(mk_req(FUNC_LOOKUP, 31, 0, 0, 0));
    // equal cost is not cheaper: poison only when hop matches sender
    drive_req(mk_req(FUNC_ADVERT, 31, 4, 4, 253));
    drive_req(mk_req(FUNC_ADVERT, 0, 10, 11, 0));
    drive_req(mk_req(FUNC_ADVERT, 0, 10, 10, 0));
    drive_req(mk_req(FUNC_DOWN, 5, 0, 0, 0));
    drive_req(mk_req(FUNC_DOWN, 31, 31, 31, 255));
    drive_req(mk_req(FUNC_LOOKUP, 0, 0, 0, 0));
    drive_req(mk_req(FUNC_SET, 20, 0, 21, 128));
    drive_req(mk_req(FUNC_DOWN, 20, 0, 0, 0));
    drive_req(mk_req(FUNC_LOOKUP, 20, 0, 0, 0));

    for (int p = 0; p < PHASES; p++)
      for (int n = 0; n < RAND_ITEMS / PHASES; n++)
        drive_req(make_random_req(p));
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // idle a while to catch any stray result beat
    repeat (NUM_NODES + 16) @(posedge clk);

    $display("requests: advertise %0d, lookup %0d, set %0d, link down %0d",
             sb.func_seen[FUNC_ADVERT], sb.func_seen[FUNC_LOOKUP],
             sb.func_seen[FUNC_SET], sb.func_seen[FUNC_DOWN]);
    $display("reports: direct %0d, default %0d, no route %0d, updated %0d, errors %0d",
             sb.status_seen[STAT_DIRECT], sb.status_seen[STAT_DEFAULT],
             sb.status_seen[STAT_NONE], sb.status_seen[STAT_UPDATED], sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: distance_vector_route_table.f
sv/dvrt_pkg.sv
sv/dvrt_in_if.sv
sv/dvrt_out_if.sv
sv/dvrt_store.sv
sv/distance_vector_route_table.sv
test/tb_distance_vector_route_table.sv
